// File: hw/rtl/edge_aligned_frequency_measure_top_assert.svh
// Assertion macros shared by the frequency measurement block.
`ifndef EDGE_ALIGNED_FREQUENCY_MEASURE_TOP_ASSERT_SVH
`define EDGE_ALIGNED_FREQUENCY_MEASURE_TOP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define EFM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define EFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/efm_pkg.sv
package efm_pkg;

   // Widths fixed by the item format
   localparam int COUNTER_WIDTH_DEFAULT = 64;
   localparam int DATA_W = 64;
   localparam int HZ_W = 32;
   localparam int ALU_W = DATA_W + 1;
   localparam int STEP_W = 6;
   localparam int MUL_STEPS = HZ_W;
   localparam int DIV_STEPS = DATA_W;
   localparam int CSR_IDX_W = 3;

   localparam logic [HZ_W-1:0] PPM_SCALE = 32'd1000000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RULER_MASK = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_MASK = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BUDGET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RULER_HZ = 3'd4;

   // Register reset values
   localparam logic [DATA_W-1:0] SPAN_RESET = 64'd1000;
   localparam logic [DATA_W-1:0] BUDGET_RESET = 64'd1000000000;
   localparam logic [HZ_W-1:0] RULER_HZ_RESET = 32'd1193182;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_TIMEOUT = 2'd1,
      ST_DEGEN = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_FIRST = 3'd1,
      PH_SPAN = 3'd2,
      PH_FRESH = 3'd3,
      PH_SECOND = 3'd4
   } phase_type;

   typedef enum logic [3:0] {
      C_IDLE,
      C_D0,
      C_D1,
      C_M0,
      C_M1,
      C_SUB,
      C_CNT,
      C_WIN,
      C_PPM_MUL,
      C_PPM_DIV,
      C_HZ_MUL,
      C_HZ_DIV,
      C_FINISH
   } calc_state_type;

   typedef struct packed {
      logic [DATA_W-1:0] ruler_mask;
      logic [DATA_W-1:0] probe_mask;
      logic [DATA_W-1:0] span;
      logic [DATA_W-1:0] budget;
      logic [HZ_W-1:0] ruler_hz;
   } cfg_type;

   typedef struct packed {
      logic emit_timeout;
      logic launch;
   } track_evt_type;

   typedef struct packed {
      status_type status;
      logic [DATA_W-1:0] ruler_counts;
      logic [DATA_W-1:0] subject_counts;
      logic [DATA_W-1:0] window;
      logic [DATA_W-1:0] frequency_hz;
      logic [DATA_W-1:0] window_ppm;
   } result_type;

endpackage

// File: hw/rtl/efm_alu.sv
module efm_alu (
   input logic [efm_pkg::ALU_W-1:0] op_a,
   input logic [efm_pkg::ALU_W-1:0] op_b,
   input logic op_sub,
   output logic [efm_pkg::ALU_W:0] sum
);

   logic [efm_pkg::ALU_W:0] b_ext;

   // Add or subtract; on subtract the top bit is set when op_a >= op_b
   always_comb begin
      b_ext = {1'b0, (op_sub ? ~op_b : op_b)};
      sum = {1'b0, op_a} + b_ext + {{efm_pkg::ALU_W{1'b0}}, op_sub};
   end

endmodule

// File: hw/rtl/efm_track.sv
module efm_track #(
   parameter int COUNTER_WIDTH = efm_pkg::COUNTER_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic accept,
   input logic restart,
   input logic [COUNTER_WIDTH-1:0] value,
   input logic [COUNTER_WIDTH-1:0] pre_read,
   input logic [COUNTER_WIDTH-1:0] after,
   input logic [efm_pkg::DATA_W-1:0] timestamp,
   input efm_pkg::cfg_type cfg,
   output efm_pkg::phase_type phase,
   output efm_pkg::track_evt_type evt,
   output logic [COUNTER_WIDTH-1:0] first_value,
   output logic [COUNTER_WIDTH-1:0] first_before,
   output logic [COUNTER_WIDTH-1:0] first_after
);

   efm_pkg::phase_type phase_ff, phase_in;
   logic [COUNTER_WIDTH-1:0] edge_ref_ff, edge_ref_in;
   logic [efm_pkg::DATA_W-1:0] start_time_ff, start_time_in;
   logic [COUNTER_WIDTH-1:0] first_value_ff, first_value_in;
   logic [COUNTER_WIDTH-1:0] first_before_ff, first_before_in;
   logic [COUNTER_WIDTH-1:0] first_after_ff, first_after_in;

   logic [efm_pkg::DATA_W-1:0] elapsed;
   logic timed_out;
   logic [COUNTER_WIDTH-1:0] span_gap;
   logic [efm_pkg::DATA_W-1:0] span_gap_ext;
   logic span_met;

   // Timeout and span checks against the current read
   always_comb begin
      elapsed = timestamp - start_time_ff;
      timed_out = elapsed > cfg.budget;
      span_gap = (value - first_value_ff) & cfg.ruler_mask[COUNTER_WIDTH-1:0];
      span_gap_ext = '0;
      span_gap_ext[COUNTER_WIDTH-1:0] = span_gap;
      span_met = span_gap_ext >= cfg.span;
   end

   // Advance the measurement phase on each transfer
   always_comb begin
      phase_in = phase_ff;
      edge_ref_in = edge_ref_ff;
      start_time_in = start_time_ff;
      first_value_in = first_value_ff;
      first_before_in = first_before_ff;
      first_after_in = first_after_ff;
      evt = '0;
      if (accept) begin
         if (restart) begin
            edge_ref_in = value;
            start_time_in = timestamp;
            phase_in = efm_pkg::PH_FIRST;
         end else begin
            case (phase_ff)
               efm_pkg::PH_FIRST: begin
                  if (value != edge_ref_ff) begin
                     first_value_in = value;
                     first_before_in = pre_read;
                     first_after_in = after;
                     phase_in = efm_pkg::PH_SPAN;
                  end else if (timed_out) begin
                     evt.emit_timeout = 1'b1;
                     phase_in = efm_pkg::PH_IDLE;
                  end
               end
               efm_pkg::PH_SPAN: begin
                  if (timed_out) begin
                     evt.emit_timeout = 1'b1;
                     phase_in = efm_pkg::PH_IDLE;
                  end else if (span_met) begin
                     phase_in = efm_pkg::PH_FRESH;
                  end
               end
               efm_pkg::PH_FRESH: begin
                  edge_ref_in = value;
                  phase_in = efm_pkg::PH_SECOND;
               end
               efm_pkg::PH_SECOND: begin
                  if (value != edge_ref_ff) begin
                     evt.launch = 1'b1;
                     phase_in = efm_pkg::PH_IDLE;
                  end else if (timed_out) begin
                     evt.emit_timeout = 1'b1;
                     phase_in = efm_pkg::PH_IDLE;
                  end
               end
               default: begin
                  phase_in = efm_pkg::PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= efm_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_ref_ff <= edge_ref_in;
      start_time_ff <= start_time_in;
      first_value_ff <= first_value_in;
      first_before_ff <= first_before_in;
      first_after_ff <= first_after_in;
   end

   assign phase = phase_ff;
   assign first_value = first_value_ff;
   assign first_before = first_before_ff;
   assign first_after = first_after_ff;

endmodule

// File: hw/rtl/efm_calc.sv
module efm_calc #(
   parameter int COUNTER_WIDTH = efm_pkg::COUNTER_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic launch,
   input logic [COUNTER_WIDTH-1:0] value,
   input logic [COUNTER_WIDTH-1:0] pre_read,
   input logic [COUNTER_WIDTH-1:0] after,
   input logic [COUNTER_WIDTH-1:0] first_value,
   input logic [COUNTER_WIDTH-1:0] first_before,
   input logic [COUNTER_WIDTH-1:0] first_after,
   input efm_pkg::cfg_type cfg,
   output logic busy,
   output logic done,
   output efm_pkg::result_type result
);

   localparam int AW = efm_pkg::ALU_W;
   localparam int DW = efm_pkg::DATA_W;

   efm_pkg::calc_state_type state_ff, state_in;
   logic [COUNTER_WIDTH-1:0] value_ff, value_in;
   logic [COUNTER_WIDTH-1:0] before_ff, before_in;
   logic [COUNTER_WIDTH-1:0] after_ff, after_in;
   logic [COUNTER_WIDTH-1:0] d0_ff, d0_in;
   logic [COUNTER_WIDTH-1:0] d1_ff, d1_in;
   logic [COUNTER_WIDTH-1:0] mid0_ff, mid0_in;
   logic [COUNTER_WIDTH-1:0] mid1_ff, mid1_in;
   logic [COUNTER_WIDTH-1:0] sub_ff, sub_in;
   logic [COUNTER_WIDTH-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] win_ff, win_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic [DW-1:0] mcand_ff, mcand_in;
   logic [efm_pkg::HZ_W-1:0] mplier_ff, mplier_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] ppm_ff, ppm_in;
   logic [DW-1:0] hz_ff, hz_in;
   logic [efm_pkg::STEP_W-1:0] step_ff, step_in;

   logic [AW-1:0] op_a, op_b;
   logic op_sub;
   logic [AW:0] alu_sum;

   logic [COUNTER_WIDTH-1:0] smask, rmask;
   logic [DW-1:0] sub_ext, cnt_ext;
   logic [AW-1:0] divisor;
   logic [AW-1:0] rem_shift;
   logic [DW-1:0] acc_next;
   logic qbit;
   logic [DW-1:0] rem_next, quo_next;
   logic degenerate;

   efm_alu u_alu (
      .op_a(op_a),
      .op_b(op_b),
      .op_sub(op_sub),
      .sum(alu_sum)
   );

   // Operand forms used by several steps
   always_comb begin
      smask = cfg.probe_mask[COUNTER_WIDTH-1:0];
      rmask = cfg.ruler_mask[COUNTER_WIDTH-1:0];
      sub_ext = '0;
      sub_ext[COUNTER_WIDTH-1:0] = sub_ff;
      cnt_ext = '0;
      cnt_ext[COUNTER_WIDTH-1:0] = cnt_ff;
      divisor = '0;
      divisor[COUNTER_WIDTH-1:0] = (state_ff == efm_pkg::C_PPM_DIV) ? sub_ff : cnt_ff;
      rem_shift = {rem_ff, quo_ff[DW-1]};
      acc_next = mplier_ff[0] ? alu_sum[DW-1:0] : acc_ff;
      qbit = alu_sum[AW];
      rem_next = qbit ? alu_sum[DW-1:0] : rem_shift[DW-1:0];
      quo_next = {quo_ff[DW-2:0], qbit};
      degenerate = (sub_ff == '0) || (cnt_ff == '0);
   end

   // Sequence the shared adder through the final computation
   always_comb begin
      state_in = state_ff;
      value_in = value_ff;
      before_in = before_ff;
      after_in = after_ff;
      d0_in = d0_ff;
      d1_in = d1_ff;
      mid0_in = mid0_ff;
      mid1_in = mid1_ff;
      sub_in = sub_ff;
      cnt_in = cnt_ff;
      win_in = win_ff;
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      ppm_in = ppm_ff;
      hz_in = hz_ff;
      step_in = step_ff;
      op_a = '0;
      op_b = '0;
      op_sub = 1'b0;
      done = 1'b0;
      case (state_ff)
         efm_pkg::C_IDLE: begin
            if (launch) begin
               value_in = value;
               before_in = pre_read;
               after_in = after;
               state_in = efm_pkg::C_D0;
            end
         end
         efm_pkg::C_D0: begin
            op_a[COUNTER_WIDTH-1:0] = first_after;
            op_b[COUNTER_WIDTH-1:0] = first_before;
            op_sub = 1'b1;
            d0_in = alu_sum[COUNTER_WIDTH-1:0] & smask;
            state_in = efm_pkg::C_D1;
         end
         efm_pkg::C_D1: begin
            op_a[COUNTER_WIDTH-1:0] = after_ff;
            op_b[COUNTER_WIDTH-1:0] = before_ff;
            op_sub = 1'b1;
            d1_in = alu_sum[COUNTER_WIDTH-1:0] & smask;
            state_in = efm_pkg::C_M0;
         end
         efm_pkg::C_M0: begin
            op_a[COUNTER_WIDTH-1:0] = first_before;
            op_b[COUNTER_WIDTH-1:0] = d0_ff >> 1;
            mid0_in = alu_sum[COUNTER_WIDTH-1:0];
            state_in = efm_pkg::C_M1;
         end
         efm_pkg::C_M1: begin
            op_a[COUNTER_WIDTH-1:0] = before_ff;
            op_b[COUNTER_WIDTH-1:0] = d1_ff >> 1;
            mid1_in = alu_sum[COUNTER_WIDTH-1:0];
            state_in = efm_pkg::C_SUB;
         end
         efm_pkg::C_SUB: begin
            op_a[COUNTER_WIDTH-1:0] = mid1_ff;
            op_b[COUNTER_WIDTH-1:0] = mid0_ff;
            op_sub = 1'b1;
            sub_in = alu_sum[COUNTER_WIDTH-1:0] & smask;
            state_in = efm_pkg::C_CNT;
         end
         efm_pkg::C_CNT: begin
            op_a[COUNTER_WIDTH-1:0] = value_ff;
            op_b[COUNTER_WIDTH-1:0] = first_value;
            op_sub = 1'b1;
            cnt_in = alu_sum[COUNTER_WIDTH-1:0] & rmask;
            state_in = efm_pkg::C_WIN;
         end
         efm_pkg::C_WIN: begin
            op_a[COUNTER_WIDTH-1:0] = d0_ff;
            op_b[COUNTER_WIDTH-1:0] = d1_ff;
            win_in = alu_sum[DW-1:0];
            if (sub_ff != '0) begin
               acc_in = '0;
               mcand_in = alu_sum[DW-1:0];
               mplier_in = efm_pkg::PPM_SCALE;
               step_in = efm_pkg::STEP_W'(efm_pkg::MUL_STEPS - 1);
               state_in = efm_pkg::C_PPM_MUL;
            end else begin
               ppm_in = '0;
               state_in = efm_pkg::C_FINISH;
            end
         end
         efm_pkg::C_PPM_MUL, efm_pkg::C_HZ_MUL: begin
            // shift-add, one multiplier bit per cycle, wraps at 64 bits
            op_a[DW-1:0] = acc_ff;
            op_b[DW-1:0] = mcand_ff;
            acc_in = acc_next;
            mcand_in = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               quo_in = acc_next;
               rem_in = '0;
               step_in = efm_pkg::STEP_W'(efm_pkg::DIV_STEPS - 1);
               state_in = (state_ff == efm_pkg::C_PPM_MUL) ? efm_pkg::C_PPM_DIV
                                                           : efm_pkg::C_HZ_DIV;
            end
         end
         efm_pkg::C_PPM_DIV, efm_pkg::C_HZ_DIV: begin
            // restoring division, one quotient bit per cycle
            op_a = rem_shift;
            op_b = divisor;
            op_sub = 1'b1;
            rem_in = rem_next;
            quo_in = quo_next;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               if (state_ff == efm_pkg::C_PPM_DIV) begin
                  ppm_in = quo_next;
                  if (cnt_ff != '0) begin
                     acc_in = '0;
                     mcand_in = sub_ext;
                     mplier_in = cfg.ruler_hz;
                     step_in = efm_pkg::STEP_W'(efm_pkg::MUL_STEPS - 1);
                     state_in = efm_pkg::C_HZ_MUL;
                  end else begin
                     state_in = efm_pkg::C_FINISH;
                  end
               end else begin
                  hz_in = quo_next;
                  state_in = efm_pkg::C_FINISH;
               end
            end
         end
         efm_pkg::C_FINISH: begin
            done = 1'b1;
            state_in = efm_pkg::C_IDLE;
         end
         default: begin
            state_in = efm_pkg::C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= efm_pkg::C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      before_ff <= before_in;
      after_ff <= after_in;
      d0_ff <= d0_in;
      d1_ff <= d1_in;
      mid0_ff <= mid0_in;
      mid1_ff <= mid1_in;
      sub_ff <= sub_in;
      cnt_ff <= cnt_in;
      win_ff <= win_in;
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ppm_ff <= ppm_in;
      hz_ff <= hz_in;
      step_ff <= step_in;
   end

   // Hand over the finished result
   always_comb begin
      result.status = degenerate ? efm_pkg::ST_DEGEN : efm_pkg::ST_OK;
      result.ruler_counts = cnt_ext;
      result.subject_counts = sub_ext;
      result.window = win_ff;
      result.frequency_hz = degenerate ? '0 : hz_ff;
      result.window_ppm = ppm_ff;
   end

   assign busy = (state_ff != efm_pkg::C_IDLE);

endmodule

// File: hw/rtl/edge_aligned_frequency_measure_top.sv
// Channel   Direction  Handshake            Carries
// req_*     in         req_valid/req_stall  restart, subject reads, ruler read, timestamp
// rsp_*     out        rsp_valid/rsp_stall  status, counts, window, frequency, ppm
// csr_*     in         csr_write_en         register index and write data
//
// An item that sees the closing edge starts the final computation on the shared
// adder: setup steps D0 to WIN, a shift-add multiply and a restoring divide for
// ppm, the same again for frequency, a finish step; fewer steps when counts or
// subject delta are zero. Reset is synchronous, active high, and returns state and
// config registers to defaults with no clearing pass. The request side stalls during
// the computation, and while a result waits when the next item could produce another.
module edge_aligned_frequency_measure_top #(
   parameter int COUNTER_WIDTH = efm_pkg::COUNTER_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic req_restart,
   input logic [63:0] req_subject_before,
   input logic [63:0] req_ruler_value,
   input logic [63:0] req_subject_after,
   input logic [63:0] req_timestamp,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic [63:0] rsp_ruler_counts,
   output logic [63:0] rsp_subject_counts,
   output logic [63:0] rsp_window,
   output logic [63:0] rsp_frequency_hz,
   output logic [63:0] rsp_window_ppm,
   input logic csr_write_en,
   input logic [efm_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [63:0] csr_wdata
);

   `include "edge_aligned_frequency_measure_top_assert.svh"

   efm_pkg::cfg_type cfg_ff, cfg_in;
   logic rsp_valid_ff, rsp_valid_in;
   efm_pkg::result_type rsp_ff, rsp_in;

   logic req_accept;
   logic [COUNTER_WIDTH-1:0] value_m, before_m, after_m;
   efm_pkg::phase_type phase;
   efm_pkg::track_evt_type evt;
   logic [COUNTER_WIDTH-1:0] first_value, first_before, first_after;
   logic calc_busy, calc_done;
   efm_pkg::result_type calc_result;
   logic may_emit;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            efm_pkg::CSR_RULER_MASK: cfg_in.ruler_mask = csr_wdata;
            efm_pkg::CSR_PROBE_MASK: cfg_in.probe_mask = csr_wdata;
            efm_pkg::CSR_SPAN: cfg_in.span = csr_wdata;
            efm_pkg::CSR_BUDGET: cfg_in.budget = csr_wdata;
            efm_pkg::CSR_RULER_HZ: cfg_in.ruler_hz = csr_wdata[efm_pkg::HZ_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ruler_mask <= '1;
         cfg_ff.probe_mask <= '1;
         cfg_ff.span <= efm_pkg::SPAN_RESET;
         cfg_ff.budget <= efm_pkg::BUDGET_RESET;
         cfg_ff.ruler_hz <= efm_pkg::RULER_HZ_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Trim item fields to the counter width
   always_comb begin
      value_m = req_ruler_value[COUNTER_WIDTH-1:0] & cfg_ff.ruler_mask[COUNTER_WIDTH-1:0];
      before_m = req_subject_before[COUNTER_WIDTH-1:0];
      after_m = req_subject_after[COUNTER_WIDTH-1:0];
   end

   // Hold off items during the computation, and items that could produce a result the output cannot take
   assign may_emit = (phase != efm_pkg::PH_IDLE) && (phase != efm_pkg::PH_FRESH);
   assign req_stall = calc_busy || (rsp_valid_ff && rsp_stall && may_emit);
   assign req_accept = req_valid && !req_stall;

   efm_track #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_track (
      .clock(clock),
      .reset(reset),
      .accept(req_accept),
      .restart(req_restart),
      .value(value_m),
      .pre_read(before_m),
      .after(after_m),
      .timestamp(req_timestamp),
      .cfg(cfg_ff),
      .phase(phase),
      .evt(evt),
      .first_value(first_value),
      .first_before(first_before),
      .first_after(first_after)
   );

   efm_calc #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_calc (
      .clock(clock),
      .reset(reset),
      .launch(evt.launch),
      .value(value_m),
      .pre_read(before_m),
      .after(after_m),
      .first_value(first_value),
      .first_before(first_before),
      .first_after(first_after),
      .cfg(cfg_ff),
      .busy(calc_busy),
      .done(calc_done),
      .result(calc_result)
   );

   // Output register: drop on transfer, load a timeout or a finished result
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      if (evt.emit_timeout) begin
         rsp_valid_in = 1'b1;
         rsp_in = '0;
         rsp_in.status = efm_pkg::ST_TIMEOUT;
      end else if (calc_done) begin
         rsp_valid_in = 1'b1;
         rsp_in = calc_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_ruler_counts = rsp_ff.ruler_counts;
   assign rsp_subject_counts = rsp_ff.subject_counts;
   assign rsp_window = rsp_ff.window;
   assign rsp_frequency_hz = rsp_ff.frequency_hz;
   assign rsp_window_ppm = rsp_ff.window_ppm;

   `EFM_ASSERT_NEXT(a_launch_starts_calc, clock, reset, evt.launch, calc_busy,
      "launch did not start the computation")
   `EFM_ASSERT_SAME(a_done_slot_free, clock, reset, calc_done, !rsp_valid_ff,
      "result finished while output still full")
   `EFM_ASSERT_SAME(a_timeout_slot_free, clock, reset, evt.emit_timeout,
      !rsp_valid_ff || !rsp_stall, "timeout raised while output blocked")
   `EFM_ASSERT_SAME(a_calc_status, clock, reset, calc_done,
      calc_result.status != efm_pkg::ST_TIMEOUT, "computation gave timeout status")

endmodule

// File: dv/tb_top.sv
module tb_top;

   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 250;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [63:0] ALL_ONES = '1;

   // Predicts the measurement results and checks them in order
   class freq_scoreboard;
      logic [63:0] ruler_mask;
      logic [63:0] probe_mask;
      logic [63:0] span;
      logic [63:0] budget;
      logic [31:0] ruler_hz;

      efm_pkg::phase_type phase;
      logic [63:0] edge_ref;
      logic [63:0] start_time;
      logic [63:0] first_value;
      logic [63:0] first_before;
      logic [63:0] first_after;

      efm_pkg::result_type pending_results[$];
      int failures;
      int results_made;

      function new();
         ruler_mask = ALL_ONES;
         probe_mask = ALL_ONES;
         span = efm_pkg::SPAN_RESET;
         budget = efm_pkg::BUDGET_RESET;
         ruler_hz = efm_pkg::RULER_HZ_RESET;
         phase = efm_pkg::PH_IDLE;
         edge_ref = '0;
         start_time = '0;
         first_value = '0;
         first_before = '0;
         first_after = '0;
         failures = 0;
         results_made = 0;
      endfunction

      function void set_register(logic [efm_pkg::CSR_IDX_W-1:0] idx, logic [63:0] val);
         case (idx)
            efm_pkg::CSR_RULER_MASK: ruler_mask = val;
            efm_pkg::CSR_PROBE_MASK: probe_mask = val;
            efm_pkg::CSR_SPAN: span = val;
            efm_pkg::CSR_BUDGET: budget = val;
            efm_pkg::CSR_RULER_HZ: ruler_hz = val[31:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function bit past_budget(logic [63:0] now);
         return (now - start_time) > budget;
      endfunction

      // Queue one result and end the run
      function void queue_result(efm_pkg::status_type st, logic [63:0] cnt,
                                 logic [63:0] sub, logic [63:0] win, logic [63:0] hz,
                                 logic [63:0] ppm);
         efm_pkg::result_type res;
         res.status = st;
         res.ruler_counts = cnt;
         res.subject_counts = sub;
         res.window = win;
         res.frequency_hz = hz;
         res.window_ppm = ppm;
         pending_results.push_back(res);
         results_made++;
         phase = efm_pkg::PH_IDLE;
      endfunction

      // Advance the measurement by one accepted read; returns 0 if it was ignored
      function bit take_sample(logic restart, logic [63:0] pre_read, logic [63:0] raw_value,
                               logic [63:0] after, logic [63:0] now);
         logic [63:0] value, d0, d1, mid0, mid1, cnt, sub, win, ppm, hz, prod;
         value = raw_value & ruler_mask;
         if (restart) begin
            edge_ref = value;
            start_time = now;
            phase = efm_pkg::PH_FIRST;
            return 1'b1;
         end
         case (phase)
            efm_pkg::PH_FIRST: begin
               if (value != edge_ref) begin
                  first_value = value;
                  first_before = pre_read;
                  first_after = after;
                  phase = efm_pkg::PH_SPAN;
               end else if (past_budget(now)) begin
                  queue_result(efm_pkg::ST_TIMEOUT, '0, '0, '0, '0, '0);
               end
            end
            efm_pkg::PH_SPAN: begin
               // timeout is checked ahead of the span
               if (past_budget(now))
                  queue_result(efm_pkg::ST_TIMEOUT, '0, '0, '0, '0, '0);
               else if (((value - first_value) & ruler_mask) >= span)
                  phase = efm_pkg::PH_FRESH;
            end
            efm_pkg::PH_FRESH: begin
               edge_ref = value;
               phase = efm_pkg::PH_SECOND;
            end
            efm_pkg::PH_SECOND: begin
               if (value == edge_ref) begin
                  if (past_budget(now))
                     queue_result(efm_pkg::ST_TIMEOUT, '0, '0, '0, '0, '0);
               end else begin
                  d0 = (first_after - first_before) & probe_mask;
                  d1 = (after - pre_read) & probe_mask;
                  mid0 = first_before + (d0 >> 1);
                  mid1 = pre_read + (d1 >> 1);
                  cnt = (value - first_value) & ruler_mask;
                  sub = (mid1 - mid0) & probe_mask;
                  win = d0 + d1;
                  prod = win * 64'(efm_pkg::PPM_SCALE);
                  ppm = (sub != 0) ? prod / sub : '0;
                  if (cnt == 0 || sub == 0) begin
                     queue_result(efm_pkg::ST_DEGEN, cnt, sub, win, '0, ppm);
                  end else begin
                     prod = sub * {32'd0, ruler_hz};
                     hz = prod / cnt;
                     queue_result(efm_pkg::ST_OK, cnt, sub, win, hz, ppm);
                  end
               end
            end
            default: return 1'b0;
         endcase
         return 1'b1;
      endfunction

      function void compare(string field, logic [63:0] want, logic [63:0] seen);
         if (seen !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, seen);
         end
      endfunction

      // Check one transferred result against the oldest prediction
      function void match_result(efm_pkg::result_type seen);
         efm_pkg::result_type want;
         if (pending_results.size() == 0) begin
            failures++;
            $display("%0t: result with none expected, expected nothing, got status %0d",
                     $time, seen.status);
            return;
         end
         want = pending_results.pop_front();
         compare("status", 64'(want.status), 64'(seen.status));
         compare("ruler_counts", want.ruler_counts, seen.ruler_counts);
         compare("subject_counts", want.subject_counts, seen.subject_counts);
         compare("window", want.window, seen.window);
         compare("frequency_hz", want.frequency_hz, seen.frequency_hz);
         compare("window_ppm", want.window_ppm, seen.window_ppm);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_restart = 1'b0;
   logic [63:0] req_subject_before = '0;
   logic [63:0] req_ruler_value = '0;
   logic [63:0] req_subject_after = '0;
   logic [63:0] req_timestamp = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [63:0] rsp_ruler_counts;
   logic [63:0] rsp_subject_counts;
   logic [63:0] rsp_window;
   logic [63:0] rsp_frequency_hz;
   logic [63:0] rsp_window_ppm;
   logic csr_write_en = 1'b0;
   logic [efm_pkg::CSR_IDX_W-1:0] csr_index = efm_pkg::CSR_RULER_MASK;
   logic [63:0] csr_wdata = '0;

   freq_scoreboard sb;
   bit calm = 1'b0;
   int rsp_wait = 0;
   int cycle_count = 0;
   int items_used = 0;
   logic [63:0] subject_now;
   logic [63:0] last_before;
   logic [63:0] last_after;
   logic [63:0] run_start;
   logic [63:0] run_elapsed;

   edge_aligned_frequency_measure_top u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_restart(req_restart),
      .req_subject_before(req_subject_before),
      .req_ruler_value(req_ruler_value),
      .req_subject_after(req_subject_after),
      .req_timestamp(req_timestamp),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_ruler_counts(rsp_ruler_counts),
      .rsp_subject_counts(rsp_subject_counts),
      .rsp_window(rsp_window),
      .rsp_frequency_hz(rsp_frequency_hz),
      .rsp_window_ppm(rsp_window_ppm),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int draw_wait();
      if (calm)
         return 0;
      return $urandom_range(0, 14);
   endfunction

   // Hold off each result for a freshly drawn number of cycles
   always @(posedge clock) begin : rsp_pacing
      if (reset)
         rsp_wait = draw_wait();
      else if (rsp_valid && !rsp_stall)
         rsp_wait = draw_wait();
      else if (rsp_valid && rsp_wait != 0)
         rsp_wait = rsp_wait - 1;
      rsp_stall <= (rsp_wait != 0);
   end

   // Check every result transfer
   always @(posedge clock) begin : result_monitor
      efm_pkg::result_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.status = efm_pkg::status_type'(rsp_status);
         seen.ruler_counts = rsp_ruler_counts;
         seen.subject_counts = rsp_subject_counts;
         seen.window = rsp_window;
         seen.frequency_hz = rsp_frequency_hz;
         seen.window_ppm = rsp_window_ppm;
         sb.match_result(seen);
      end
   end

   // Present one read and hold it until the transfer
   task automatic send_item(input logic rs, input logic [63:0] b, input logic [63:0] v,
                            input logic [63:0] a, input logic [63:0] t);
      int gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= rs;
      req_subject_before <= b;
      req_ruler_value <= v;
      req_subject_after <= a;
      req_timestamp <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (sb.take_sample(rs, b, v, a, t))
         items_used++;
   endtask

   // Build a bracketed read: subject pair, timestamp, ruler value with junk above the mask
   task automatic send_read(input logic rs, input logic [63:0] v, input logic late,
                            input logic pinned = 1'b0,
                            input logic [63:0] pb = 64'd0, input logic [63:0] pa = 64'd0);
      logic [63:0] b, a, ts, step, rm;
      rm = sb.ruler_mask;
      if (pinned) begin
         b = pb;
         a = pa;
      end else begin
         b = subject_now;
         a = ($urandom_range(0, 15) == 0) ? rand64() : b + 64'($urandom_range(0, 40));
         subject_now = subject_now + 64'($urandom_range(1, 5000));
      end
      last_before = b;
      last_after = a;
      if (rs) begin
         run_start = rand64();
         run_elapsed = '0;
         ts = run_start;
      end else if (late) begin
         ts = run_start + sb.budget + 64'd1 + 64'($urandom_range(0, 99));
      end else begin
         step = (sb.budget >> 4) * 64'($urandom_range(0, 3)) + 64'($urandom_range(0, 1));
         if (sb.budget - run_elapsed < step)
            run_elapsed = sb.budget;
         else
            run_elapsed = run_elapsed + step;
         ts = run_start + run_elapsed;
      end
      send_item(rs, b, (v & rm) | (rand64() & ~rm), a, ts);
   endtask

   // One measurement, sometimes cut short or ended by a timeout
   task automatic run_measurement();
      logic [63:0] rm, base, first_val, fresh, second, fb, fa;
      int abort_at;
      bit zero_counts, zero_delta;
      rm = sb.ruler_mask;
      abort_at = $urandom_range(0, 9);
      zero_counts = ($urandom_range(0, 7) == 0);
      zero_delta = ($urandom_range(0, 7) == 0);
      base = rand64() & rm;
      send_read(1'b1, base, 1'b0);
      repeat ($urandom_range(0, 2)) send_read(1'b0, base, 1'b0);
      if (abort_at == 1) begin
         send_read(1'b0, base, 1'b1);
         return;
      end
      // first edge, now and then past the budget
      first_val = (base + 64'($urandom_range(1, 3))) & rm;
      send_read(1'b0, first_val, $urandom_range(0, 5) == 0);
      fb = last_before;
      fa = last_after;
      if (abort_at == 4 && $urandom_range(0, 1) == 0)
         return;
      // span wait: short of the span, then at or past it
      repeat ($urandom_range(0, 2)) send_read(1'b0, first_val + (sb.span >> 1), 1'b0);
      if (abort_at == 2) begin
         send_read(1'b0, rand64(), 1'b1);
         return;
      end
      send_read(1'b0, first_val + sb.span + 64'($urandom_range(0, 2)), 1'b0);
      fresh = (zero_counts ? first_val + 64'd1 : rand64()) & rm;
      send_read(1'b0, fresh, $urandom_range(0, 7) == 0);
      if (abort_at == 4)
         return;
      repeat ($urandom_range(0, 2)) send_read(1'b0, fresh, 1'b0);
      if (abort_at == 3) begin
         send_read(1'b0, fresh, 1'b1);
         return;
      end
      second = zero_counts ? first_val : fresh + 64'($urandom_range(1, 65535));
      send_read(1'b0, second, $urandom_range(0, 5) == 0, zero_delta, fb, fa);
   endtask

   task automatic random_phase(input int item_goal, input int result_goal);
      int first_item, first_result;
      first_item = items_used;
      first_result = sb.results_made;
      while ((items_used - first_item < item_goal ||
              sb.results_made - first_result < result_goal) &&
             items_used - first_item < 3 * item_goal) begin
         calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0) begin
            // raw noise, mostly dropped while idle
            repeat ($urandom_range(1, 4))
               send_item($urandom_range(0, 7) == 0, rand64(), rand64(), rand64(), rand64());
         end else begin
            run_measurement();
         end
      end
      calm = 1'b0;
   endtask

   // Drop valid and wait until the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [efm_pkg::CSR_IDX_W-1:0] idx, input logic [63:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_register(idx, val);
   endtask

   task automatic program_registers(input logic [63:0] rmask, input logic [63:0] smask,
                                    input logic [63:0] spn, input logic [63:0] bud,
                                    input logic [63:0] hz);
      csr_put(efm_pkg::CSR_RULER_MASK, rmask);
      csr_put(efm_pkg::CSR_PROBE_MASK, smask);
      csr_put(efm_pkg::CSR_SPAN, spn);
      csr_put(efm_pkg::CSR_BUDGET, bud);
      csr_put(efm_pkg::CSR_RULER_HZ, hz);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [63:0] width_mask(int bits);
      return (bits >= 64) ? ALL_ONES : (64'd1 << bits) - 64'd1;
   endfunction

   initial begin : stimulus
      sb = new();
      subject_now = rand64();
      run_start = '0;
      run_elapsed = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // idle read without restart is dropped
      send_item(1'b0, rand64(), rand64(), rand64(), rand64());
      // clean run: subject wraps, span met exactly, elapsed exactly at the budget
      send_item(1'b1, 64'd0, 64'd0, ALL_ONES, 64'd0);
      send_item(1'b0, 64'hFFFF_FFFF_FFFF_FFF0, 64'd1, 64'h10, 64'd10);
      send_item(1'b0, 64'h100, 64'd1 + efm_pkg::SPAN_RESET, 64'h104, efm_pkg::BUDGET_RESET);
      // fresh read is never timed; a late closing edge still gives a result
      send_item(1'b0, rand64(), ALL_ONES, rand64(), ALL_ONES);
      send_item(1'b0, 64'd5000, 64'd0, 64'd5010, ALL_ONES);
      // timeout before the first edge, start time near wrap
      send_item(1'b1, 64'd0, 64'd5, 64'd0, 64'hFFFF_FFFF_FFFF_FFF0);
      send_item(1'b0, 64'd1, 64'd5, 64'd2,
                64'hFFFF_FFFF_FFFF_FFF0 + efm_pkg::BUDGET_RESET + 64'd1);
      // timeout in the span wait wins over the span being met
      send_item(1'b1, 64'd0, 64'd7, 64'd0, 64'd100);
      send_item(1'b0, 64'd10, 64'd8, 64'd12, 64'd200);
      send_item(1'b0, 64'd20, 64'd8 + efm_pkg::SPAN_RESET, 64'd22,
                64'd101 + efm_pkg::BUDGET_RESET);
      // timeout waiting for the closing edge
      send_item(1'b1, 64'd0, 64'd20, 64'd0, 64'd0);
      send_item(1'b0, 64'd100, 64'd21, 64'd104, 64'd1);
      send_item(1'b0, 64'd200, 64'd21 + efm_pkg::SPAN_RESET, 64'd204, 64'd2);
      send_item(1'b0, 64'd300, 64'd40, 64'd310, 64'd3);
      send_item(1'b0, 64'd400, 64'd40, 64'd402, efm_pkg::BUDGET_RESET + 64'd1);
      // closing edge lands on the first edge value, so the ruler delta is zero
      send_item(1'b1, 64'd0, 64'd30, 64'd0, 64'd0);
      send_item(1'b0, 64'd1000, 64'd31, 64'd1002, 64'd1);
      send_item(1'b0, 64'd1100, 64'd31 + efm_pkg::SPAN_RESET, 64'd1100, 64'd2);
      send_item(1'b0, 64'd1200, 64'd40, 64'd1201, 64'd3);
      send_item(1'b0, 64'd1300, 64'd31, 64'd1310, 64'd4);
      // same subject reads at both edges: zero subject delta
      send_item(1'b1, 64'd0, 64'd50, 64'd0, 64'd0);
      send_item(1'b0, 64'd500, 64'd51, 64'd500, 64'd1);
      send_item(1'b0, 64'd600, 64'd51 + efm_pkg::SPAN_RESET, 64'd601, 64'd2);
      send_item(1'b0, 64'd700, 64'd60, 64'd701, 64'd3);
      send_item(1'b0, 64'd500, 64'd61, 64'd500, 64'd4);
      settle();

      // narrow counters, short span and budget; junk above the rate width
      program_registers(64'hFFFF, 64'hFF_FFFF, 64'd50, 64'd5000, rand64());
      random_phase(90, 12);
      settle();

      // full width, zero span, zero budget, fastest reference
      program_registers(ALL_ONES, ALL_ONES, 64'd0, 64'd0, 64'hFFFF_FFFF);
      random_phase(90, 12);
      settle();

      // reference never moves, span unreachable, slowest reference
      program_registers(64'd0, 64'd0, ALL_ONES, 64'd300, 64'd1);
      random_phase(50, 6);
      settle();

      // random widths and limits
      program_registers(width_mask($urandom_range(16, 64)), width_mask($urandom_range(16, 64)),
                        64'($urandom_range(0, 2000)), rand64() >> $urandom_range(0, 63),
                        64'($urandom));
      random_phase(100, 12);
      settle();

      // budget never runs out
      program_registers(64'hFF_FFFF, ALL_ONES, efm_pkg::SPAN_RESET, ALL_ONES,
                        64'(efm_pkg::RULER_HZ_RESET));
      random_phase(70, 12);
      settle();

      if (sb.failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
